// File: src/http_chunked_body_decoder_defines.svh
// Assertion helpers used by the checker file.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define CHDEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define CHDEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/chdec_pkg.sv
`timescale 1ns / 1ps

package chdec_pkg;

    localparam int SIZE_BITS   = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [3:0] {
        PH_SIZE       = 4'd0,
        PH_EXT        = 4'd1,
        PH_SIZE_LF    = 4'd2,
        PH_DATA       = 4'd3,
        PH_DATA_CR    = 4'd4,
        PH_DATA_LF    = 4'd5,
        PH_TRAILER    = 4'd6,
        PH_TRAILER_LF = 4'd7,
        PH_DONE       = 4'd8,
        PH_FAIL       = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        ST_PAYLOAD   = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_BAD_DIGIT = 3'd2,
        ST_NO_CRLF   = 3'd3,
        ST_OVERFLOW  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Decode one ASCII hex digit of either case.
    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// File: src/chdec_front.sv
`timescale 1ns / 1ps

module chdec_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_queue_full,
    output logic                 o_ready,
    output logic                 o_push,
    output chdec_pkg::t_result   o_result
);

    chdec_pkg::t_phase                     r_phase, n_phase;
    logic [chdec_pkg::SIZE_BITS-1:0]       r_bytes_left, n_bytes_left;
    logic                                  r_digit_seen, n_digit_seen;
    logic                                  r_line_empty, n_line_empty;

    logic                                  w_accept;
    chdec_pkg::t_hex                       w_hex;
    logic                                  w_is_cr, w_is_lf, w_is_sep;
    logic                                  w_top_busy;
    logic                                  w_last_byte;

    assign o_ready     = !i_queue_full;
    assign w_accept    = i_valid && o_ready;
    assign w_hex       = chdec_pkg::hex_value(i_data_byte);
    assign w_is_cr     = (i_data_byte == chdec_pkg::CH_CR);
    assign w_is_lf     = (i_data_byte == chdec_pkg::CH_LF);
    assign w_is_sep    = (i_data_byte == chdec_pkg::CH_SPACE) ||
                         (i_data_byte == chdec_pkg::CH_SEMI);
    // A further digit would push the size out of range.
    assign w_top_busy  = (r_bytes_left[chdec_pkg::SIZE_BITS-1 -: 4] != 4'd0);
    assign w_last_byte = (r_bytes_left == chdec_pkg::SIZE_BITS'(1));

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_digit_seen = r_digit_seen;
        n_line_empty = r_line_empty;
        if (w_accept) begin
            unique case (r_phase)
                chdec_pkg::PH_SIZE: begin
                    if (w_hex.ok) begin
                        if (w_top_busy) begin
                            n_phase = chdec_pkg::PH_FAIL;
                        end else begin
                            n_bytes_left = {r_bytes_left[chdec_pkg::SIZE_BITS-5:0], w_hex.val};
                            n_digit_seen = 1'b1;
                        end
                    end else if (!r_digit_seen) begin
                        n_phase = chdec_pkg::PH_FAIL;
                    end else if (w_is_sep) begin
                        n_phase = chdec_pkg::PH_EXT;
                    end else if (w_is_cr) begin
                        n_phase = chdec_pkg::PH_SIZE_LF;
                    end else begin
                        n_phase = chdec_pkg::PH_FAIL;
                    end
                end
                chdec_pkg::PH_EXT: begin
                    if (w_is_cr) begin
                        n_phase = chdec_pkg::PH_SIZE_LF;
                    end
                end
                chdec_pkg::PH_SIZE_LF: begin
                    if (!w_is_lf) begin
                        n_phase = chdec_pkg::PH_FAIL;
                    end else if (r_bytes_left == '0) begin
                        n_line_empty = 1'b1;
                        n_phase      = chdec_pkg::PH_TRAILER;
                    end else begin
                        n_phase = chdec_pkg::PH_DATA;
                    end
                end
                chdec_pkg::PH_DATA: begin
                    n_bytes_left = r_bytes_left - chdec_pkg::SIZE_BITS'(1);
                    if (w_last_byte) begin
                        n_phase = chdec_pkg::PH_DATA_CR;
                    end
                end
                chdec_pkg::PH_DATA_CR: begin
                    n_phase = w_is_cr ? chdec_pkg::PH_DATA_LF : chdec_pkg::PH_FAIL;
                end
                chdec_pkg::PH_DATA_LF: begin
                    if (w_is_lf) begin
                        n_phase      = chdec_pkg::PH_SIZE;
                        n_bytes_left = '0;
                        n_digit_seen = 1'b0;
                    end else begin
                        n_phase = chdec_pkg::PH_FAIL;
                    end
                end
                chdec_pkg::PH_TRAILER: begin
                    if (w_is_cr) begin
                        n_phase = chdec_pkg::PH_TRAILER_LF;
                    end else begin
                        n_line_empty = 1'b0;
                    end
                end
                chdec_pkg::PH_TRAILER_LF: begin
                    if (!w_is_lf) begin
                        n_phase = chdec_pkg::PH_FAIL;
                    end else if (r_line_empty) begin
                        n_phase = chdec_pkg::PH_DONE;
                    end else begin
                        n_line_empty = 1'b1;
                        n_phase      = chdec_pkg::PH_TRAILER;
                    end
                end
                chdec_pkg::PH_DONE, chdec_pkg::PH_FAIL: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Result generation
    always_comb begin
        o_push          = 1'b0;
        o_result.data   = 8'd0;
        o_result.status = chdec_pkg::ST_PAYLOAD;
        if (w_accept) begin
            unique case (r_phase)
                chdec_pkg::PH_SIZE: begin
                    if (w_hex.ok) begin
                        if (w_top_busy) begin
                            o_push          = 1'b1;
                            o_result.status = chdec_pkg::ST_OVERFLOW;
                        end
                    end else if (!r_digit_seen || !(w_is_sep || w_is_cr)) begin
                        o_push          = 1'b1;
                        o_result.status = chdec_pkg::ST_BAD_DIGIT;
                    end
                end
                chdec_pkg::PH_SIZE_LF: begin
                    if (!w_is_lf) begin
                        o_push          = 1'b1;
                        o_result.status = chdec_pkg::ST_BAD_DIGIT;
                    end
                end
                chdec_pkg::PH_DATA: begin
                    o_push        = 1'b1;
                    o_result.data = i_data_byte;
                end
                chdec_pkg::PH_DATA_CR: begin
                    if (!w_is_cr) begin
                        o_push          = 1'b1;
                        o_result.status = chdec_pkg::ST_NO_CRLF;
                    end
                end
                chdec_pkg::PH_DATA_LF: begin
                    if (!w_is_lf) begin
                        o_push          = 1'b1;
                        o_result.status = chdec_pkg::ST_NO_CRLF;
                    end
                end
                chdec_pkg::PH_TRAILER_LF: begin
                    if (!w_is_lf) begin
                        o_push          = 1'b1;
                        o_result.status = chdec_pkg::ST_NO_CRLF;
                    end else if (r_line_empty) begin
                        o_push          = 1'b1;
                        o_result.status = chdec_pkg::ST_COMPLETE;
                    end
                end
                chdec_pkg::PH_EXT, chdec_pkg::PH_TRAILER,
                chdec_pkg::PH_DONE, chdec_pkg::PH_FAIL: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= chdec_pkg::PH_SIZE;
            r_bytes_left <= '0;
            r_digit_seen <= 1'b0;
            r_line_empty <= 1'b1;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_digit_seen <= n_digit_seen;
            r_line_empty <= n_line_empty;
        end
    end

endmodule

// File: src/chdec_fifo.sv
`timescale 1ns / 1ps

module chdec_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  chdec_pkg::t_result   i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output chdec_pkg::t_result   o_data
);

    chdec_pkg::t_result                r_mem [chdec_pkg::QUEUE_DEPTH];
    logic [chdec_pkg::QUEUE_AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [chdec_pkg::QUEUE_AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [chdec_pkg::QUEUE_CW-1:0]    r_count, n_count;
    logic                              w_wr, w_rd;

    assign o_full  = (r_count == chdec_pkg::QUEUE_CW'(chdec_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == chdec_pkg::QUEUE_AW'(chdec_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + chdec_pkg::QUEUE_AW'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == chdec_pkg::QUEUE_AW'(chdec_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + chdec_pkg::QUEUE_AW'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + chdec_pkg::QUEUE_CW'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - chdec_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: src/chdec_back.sv
`timescale 1ns / 1ps

module chdec_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_queue_empty,
    input  chdec_pkg::t_result   i_result,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_payload_byte,
    output logic [2:0]           o_status
);

    logic                  r_valid, n_valid;
    chdec_pkg::t_result    r_result;

    // Refill the output register whenever it is empty or being drained.
    assign o_pop   = !i_queue_empty && (!r_valid || i_ready);
    assign n_valid = o_pop ? 1'b1 : (i_ready ? 1'b0 : r_valid);

    assign o_valid        = r_valid;
    assign o_payload_byte = r_result.data;
    assign o_status       = r_result.status;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// File: src/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// HTTP/1.1 chunked transfer-coding body decoder.
// Input channel: i_valid / o_ready carry one body byte (i_data_byte) per
// transaction. Output channel: o_valid / i_ready carry one result per
// transaction: o_status 0 with a payload byte, 1 body complete, 2 bad size
// line, 3 missing CRLF after data or in the trailer, 4 chunk size overflow.
// Size lines, extensions, CRLFs and trailer lines produce no result.
// Throughput: one byte accepted every clock cycle while the output side
// keeps up; the parser handles each byte in the cycle it is accepted.
// Path: a result is pushed into the four-entry queue at the accepting
// edge and moves on into the output register, which drives the ports, once
// it is at the head of the queue and that register is empty or being drained.
// Stall: when i_ready is low the output register holds its transaction and
// the queue absorbs up to four further results; o_ready drops only while
// the queue is full, so bytes that produce no result also wait then.
// After body complete or any error every further byte is accepted and
// dropped until reset. Reset (i_rst_n low, synchronous) returns the parser
// to expecting a size line and empties the queue and output register.
module http_chunked_body_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic [2:0] o_status
);

    logic                 w_push;
    chdec_pkg::t_result   w_push_data;
    logic                 w_full;
    logic                 w_pop;
    logic                 w_empty;
    chdec_pkg::t_result   w_head;

    // Front: accept and parse bytes, push payload and terminal results.
    chdec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_queue_full (w_full),
        .o_ready      (o_ready),
        .o_push       (w_push),
        .o_result     (w_push_data)
    );

    // Queue: decouple the parser from output stalls.
    chdec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    // Back: registered output stage towards the receiver.
    chdec_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_queue_empty  (w_empty),
        .i_result       (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_payload_byte (o_payload_byte),
        .o_status       (o_status)
    );

endmodule

// File: src/chdec_checker.sv
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_defines.svh"

module chdec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_payload_byte,
    input logic [2:0] o_status
);

    logic w_terminal;

    assign w_terminal = (o_status != chdec_pkg::ST_PAYLOAD);

    `CHDEC_ASSERT_NOW(a_status_known, i_clk, i_rst_n, o_valid, (o_status == chdec_pkg::ST_PAYLOAD) || (o_status == chdec_pkg::ST_COMPLETE) || (o_status == chdec_pkg::ST_BAD_DIGIT) || (o_status == chdec_pkg::ST_NO_CRLF) || (o_status == chdec_pkg::ST_OVERFLOW), "unknown status code")
    `CHDEC_ASSERT_NOW(a_terminal_zero, i_clk, i_rst_n, o_valid && w_terminal, o_payload_byte == 8'd0, "terminal result carries a payload byte")
    `CHDEC_ASSERT_NEXT(a_terminal_last, i_clk, i_rst_n, o_valid && i_ready && w_terminal, !o_valid, "result after body complete or error")
    `CHDEC_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_payload_byte) && $stable(o_status), "stalled result changed")

endmodule

bind http_chunked_body_decoder chdec_checker u_chdec_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_payload_byte (o_payload_byte),
    .o_status       (o_status)
);

// File: tb/sv/chdec_result_check.sv
`timescale 1ns / 1ps

// Watches both channels of the chunked body decoder, predicts the result of
// every accepted byte and compares each output transaction with the oldest
// prediction still waiting.
module chdec_result_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic [2:0] i_out_status,
    output int         o_mismatches,
    output int         o_pending
);

    // Predictor state
    chdec_pkg::t_phase                  parse_phase;
    logic [chdec_pkg::SIZE_BITS-1:0]    chunk_left;
    logic                               size_digit_seen;
    logic                               trailer_empty;

    chdec_pkg::t_result                 expected_results[$];
    int                                 mismatch_count = 0;

    task report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] chdec check: %s", $time, what);
    endtask

    // {valid, value} of an ASCII hex digit, either case
    function automatic logic [4:0] decode_hex(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            return {1'b1, 4'(c[2:0] + 3'd1) + 4'd8};
        end
        return 5'd0;
    endfunction

    task abort_body(input chdec_pkg::t_status why);
        parse_phase = chdec_pkg::PH_FAIL;
        expected_results.push_back('{data: 8'h00, status: why});
    endtask

    task predict_byte(input logic [7:0] c);
        logic [4:0] digit;
        digit = decode_hex(c);
        case (parse_phase)
            chdec_pkg::PH_SIZE: begin
                if (digit[4]) begin
                    if (chunk_left[chdec_pkg::SIZE_BITS-1 -: 4] != '0) begin
                        abort_body(chdec_pkg::ST_OVERFLOW);
                    end else begin
                        chunk_left      = {chunk_left[chdec_pkg::SIZE_BITS-5:0], digit[3:0]};
                        size_digit_seen = 1'b1;
                    end
                end else if (!size_digit_seen) begin
                    abort_body(chdec_pkg::ST_BAD_DIGIT);
                end else if (c == chdec_pkg::CH_SPACE || c == chdec_pkg::CH_SEMI) begin
                    parse_phase = chdec_pkg::PH_EXT;
                end else if (c == chdec_pkg::CH_CR) begin
                    parse_phase = chdec_pkg::PH_SIZE_LF;
                end else begin
                    abort_body(chdec_pkg::ST_BAD_DIGIT);
                end
            end
            chdec_pkg::PH_EXT: begin
                if (c == chdec_pkg::CH_CR) parse_phase = chdec_pkg::PH_SIZE_LF;
            end
            chdec_pkg::PH_SIZE_LF: begin
                if (c != chdec_pkg::CH_LF) begin
                    abort_body(chdec_pkg::ST_BAD_DIGIT);
                end else if (chunk_left == '0) begin
                    trailer_empty = 1'b1;
                    parse_phase   = chdec_pkg::PH_TRAILER;
                end else begin
                    parse_phase = chdec_pkg::PH_DATA;
                end
            end
            chdec_pkg::PH_DATA: begin
                chunk_left = chunk_left - 1'b1;
                if (chunk_left == '0) parse_phase = chdec_pkg::PH_DATA_CR;
                expected_results.push_back('{data: c, status: chdec_pkg::ST_PAYLOAD});
            end
            chdec_pkg::PH_DATA_CR: begin
                if (c != chdec_pkg::CH_CR) abort_body(chdec_pkg::ST_NO_CRLF);
                else parse_phase = chdec_pkg::PH_DATA_LF;
            end
            chdec_pkg::PH_DATA_LF: begin
                if (c != chdec_pkg::CH_LF) begin
                    abort_body(chdec_pkg::ST_NO_CRLF);
                end else begin
                    parse_phase     = chdec_pkg::PH_SIZE;
                    chunk_left      = '0;
                    size_digit_seen = 1'b0;
                end
            end
            chdec_pkg::PH_TRAILER: begin
                if (c == chdec_pkg::CH_CR) parse_phase = chdec_pkg::PH_TRAILER_LF;
                else trailer_empty = 1'b0;
            end
            chdec_pkg::PH_TRAILER_LF: begin
                if (c != chdec_pkg::CH_LF) begin
                    abort_body(chdec_pkg::ST_NO_CRLF);
                end else if (trailer_empty) begin
                    parse_phase = chdec_pkg::PH_DONE;
                    expected_results.push_back('{data: 8'h00,
                                                 status: chdec_pkg::ST_COMPLETE});
                end else begin
                    trailer_empty = 1'b1;
                    parse_phase   = chdec_pkg::PH_TRAILER;
                end
            end
            default: ;  // done or failed: drop the byte
        endcase
    endtask

    always @(posedge i_clk) begin
        chdec_pkg::t_result want;
        if (!i_rst_n) begin
            parse_phase     = chdec_pkg::PH_SIZE;
            chunk_left      = '0;
            size_digit_seen = 1'b0;
            trailer_empty   = 1'b1;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d byte %02h",
                                              i_out_status, i_out_byte));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  i_out_status, want.status.name()));
                    end
                    if (i_out_byte !== want.data) begin
                        report_mismatch($sformatf("payload byte %02h, expected %02h",
                                                  i_out_byte, want.data));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_byte(i_in_byte);
            end
        end
        o_pending    <= expected_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Top of the chunked body decoder bench: builds one long chunked body,
// drives it byte by byte with random gaps, throttles the result side and
// gives the verdict once the result checker has nothing left waiting.
module tb_top;

    localparam int BODY_TARGET = 940;   // rough length of the well-formed part
    localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
    localparam int HOLD_BURST  = 30;    // receiver burst at which to hold off
    localparam int TAIL_CYCLES = 16;    // drain time after the last result

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_payload_byte;
    logic [2:0] o_status;

    int         n_mismatches;
    int         n_pending;

    // Whole body, built before reset is released
    logic [7:0] body_stream[$];

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    http_chunked_body_decoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_payload_byte (o_payload_byte),
        .o_status       (o_status)
    );

    chdec_result_check result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_byte    (i_data_byte),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_byte   (o_payload_byte),
        .i_out_status (o_status),
        .o_mismatches (n_mismatches),
        .o_pending    (n_pending)
    );

    // Mostly back-to-back, now and then a short pause, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Any byte but the one given
    function automatic logic [7:0] any_but(input logic [7:0] avoid);
        logic [7:0] b;
        b = avoid;
        while (b == avoid) b = 8'($urandom);
        return b;
    endfunction

    // Hex digit character, letters in a random case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    // A character that can never be part of a size line
    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(0, 3))
            0: return 8'h67 + 8'($urandom_range(0, 19));   // g..z
            1: return 8'h80 + 8'($urandom_range(0, 127));
            2: return chdec_pkg::CH_LF;
            default: return 8'h3C + 8'($urandom_range(0, 4));  // < = > ? @
        endcase
    endfunction

    task push_crlf();
        body_stream.push_back(chdec_pkg::CH_CR);
        body_stream.push_back(chdec_pkg::CH_LF);
    endtask

    // Emit a size line: optional leading zeros, the digits, an optional
    // extension of random text, then CR LF
    task add_size_line(input logic [31:0] size, input int zeros, input bit with_ext);
        int ndig;
        ndig = 1;
        for (int i = 1; i < 8; i++) begin
            if (size[4*i +: 4] != 4'd0) ndig = i + 1;
        end
        repeat (zeros) body_stream.push_back(8'h30);
        for (int i = ndig - 1; i >= 0; i--) body_stream.push_back(hex_char(size[4*i +: 4]));
        if (with_ext) begin
            body_stream.push_back($urandom_range(0, 1) ? chdec_pkg::CH_SPACE
                                                       : chdec_pkg::CH_SEMI);
            repeat ($urandom_range(0, 6)) body_stream.push_back(any_but(chdec_pkg::CH_CR));
        end
        push_crlf();
    endtask

    task add_chunk(input int size, input int zeros, input bit with_ext);
        add_size_line(size, zeros, with_ext);
        repeat (size) body_stream.push_back(8'($urandom));
        push_crlf();
    endtask

    // Close the body in one of its possible ways; only one is reachable per
    // run, since the block ignores everything after completion or an error
    task add_closing();
        int how;
        int len;
        how = $urandom_range(0, 11);
        case (how)
            0, 1, 2, 3: begin
                // last chunk, a few trailer lines, then the empty line
                add_size_line(0, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 2)) begin
                    repeat ($urandom_range(1, 10)) begin
                        body_stream.push_back(any_but(chdec_pkg::CH_CR));
                    end
                    push_crlf();
                end
                push_crlf();
            end
            4: begin
                // stray character in the size
                body_stream.push_back(hex_char(4'($urandom)));
                body_stream.push_back(non_hex_char());
            end
            5: begin
                // size line with no digit at all
                case ($urandom_range(0, 2))
                    0: body_stream.push_back(chdec_pkg::CH_CR);
                    1: body_stream.push_back(chdec_pkg::CH_SPACE);
                    default: body_stream.push_back(chdec_pkg::CH_SEMI);
                endcase
            end
            6: begin
                // CR on the size line not followed by LF
                body_stream.push_back(hex_char(4'($urandom_range(1, 15))));
                body_stream.push_back(chdec_pkg::CH_CR);
                body_stream.push_back(any_but(chdec_pkg::CH_LF));
            end
            7: begin
                // nine significant digits, behind some leading zeros
                repeat ($urandom_range(0, 3)) body_stream.push_back(8'h30);
                body_stream.push_back(hex_char(4'($urandom_range(1, 15))));
                repeat (8) body_stream.push_back(hex_char(4'($urandom)));
            end
            8: begin
                // data not followed by CR LF
                len = $urandom_range(1, 4);
                add_size_line(len, 0, 0);
                repeat (len) body_stream.push_back(8'($urandom));
                if ($urandom_range(0, 1)) begin
                    body_stream.push_back(any_but(chdec_pkg::CH_CR));
                end else begin
                    body_stream.push_back(chdec_pkg::CH_CR);
                    body_stream.push_back(any_but(chdec_pkg::CH_LF));
                end
            end
            9: begin
                // bare CR in the trailer
                add_size_line(0, 0, 0);
                repeat ($urandom_range(0, 5)) body_stream.push_back(any_but(chdec_pkg::CH_CR));
                body_stream.push_back(chdec_pkg::CH_CR);
                body_stream.push_back(any_but(chdec_pkg::CH_LF));
            end
            10: begin
                // widest size that still fits; stop inside its data
                add_size_line(32'hFFFF_FFFF, $urandom_range(0, 2), 0);
                repeat (20) body_stream.push_back(8'($urandom));
                return;
            end
            default: begin
                // all-ones size then one more digit
                repeat (8) body_stream.push_back(hex_char(4'hF));
                body_stream.push_back(hex_char(4'($urandom)));
            end
        endcase
        // bytes after the end must be swallowed without a result
        repeat (8) body_stream.push_back(8'($urandom));
    endtask

    // Offer one byte: idle for a gap, then hold valid until the handshake
    task send_byte(input logic [7:0] b, input bit steady);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stimulus and verdict
    initial begin
        bit steady;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data_byte <= 8'h00;
        steady      = 1'b0;

        // Directed opening: one-byte chunk of zero, a space extension with
        // text and a leading zero over data holding LF, then an empty
        // semicolon extension over data holding CR and the top bit
        add_size_line(1, 0, 0);
        body_stream.push_back(8'h00);
        push_crlf();
        body_stream.push_back(8'h30);
        body_stream.push_back(8'h32);
        body_stream.push_back(chdec_pkg::CH_SPACE);
        body_stream.push_back(8'h78);
        push_crlf();
        body_stream.push_back(8'hFF);
        body_stream.push_back(chdec_pkg::CH_LF);
        push_crlf();
        body_stream.push_back(8'h33);
        body_stream.push_back(chdec_pkg::CH_SEMI);
        push_crlf();
        body_stream.push_back(chdec_pkg::CH_CR);
        body_stream.push_back(8'h7F);
        body_stream.push_back(8'h80);
        push_crlf();

        // Random well-formed chunks, mostly small, now and then a big one
        // or one with a long run of leading zeros
        while (body_stream.size() < BODY_TARGET) begin
            add_chunk(($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12)
                                                  : $urandom_range(0, 1),
                      $urandom_range(0, 3) == 0);
        end
        add_closing();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (body_stream[i]) begin
            // switch between gapped and back-to-back stretches
            if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
            send_byte(body_stream[i], steady);
        end
        i_valid <= 1'b0;

        // let the last prediction land, then drain
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_mismatches == 0 && n_pending == 0) begin
            $display("http_chunked_body_decoder: match");
        end else begin
            $display("http_chunked_body_decoder: mismatch");
        end
        $finish;
    end

    // Result side: alternate random hold-offs and ready runs; once, hold off
    // long enough for the result queue to fill and stall the input
    initial begin
        int burst;
        int gap;
        i_ready <= 1'b0;
        burst   = 0;
        @(posedge i_rst_n);
        @(posedge i_clk);
        forever begin
            if (burst == HOLD_BURST) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat (($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                               : $urandom_range(20, 60)) @(posedge i_clk);
            burst++;
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("http_chunked_body_decoder: mismatch");
        $finish;
    end

endmodule
